// ===== rtl/core/bounded_key_value_table_defines.svh =====
// assertion macros for the key/value table checks
`ifndef BOUNDED_KEY_VALUE_TABLE_DEFINES_SVH
`define BOUNDED_KEY_VALUE_TABLE_DEFINES_SVH

// checked only while out of reset
`define BKVT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BKVT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bkvt_pkg.sv =====
`timescale 1ns / 1ps
package bkvt_pkg;

    localparam int FUNC_W      = 3;
    localparam int INDEX_W     = 8;
    localparam int CAP_W       = 9;
    localparam int COUNT_OUT_W = 9;

    localparam int DEF_DEPTH       = 256;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_INSERT = 3'd0;
    localparam t_func FUNC_UPDATE = 3'd1;
    localparam t_func FUNC_UPSERT = 3'd2;
    localparam t_func FUNC_ERASE  = 3'd3;
    localparam t_func FUNC_LOOKUP = 3'd4;
    localparam t_func FUNC_READ   = 3'd5;

endpackage

// ===== rtl/core/bkvt_req_if.sv =====
`timescale 1ns / 1ps
interface bkvt_req_if #(
    parameter int KEY_W   = bkvt_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_W = bkvt_pkg::DEF_VALUE_WIDTH
) ();
    import bkvt_pkg::*;

    logic                 valid;
    logic                 ready;
    t_func                func;
    logic [KEY_W-1:0]     req_key;
    logic [VALUE_W-1:0]   req_value;
    logic [INDEX_W-1:0]   req_index;

    modport source (output valid, func, req_key, req_value, req_index, input ready);
    modport sink   (input valid, func, req_key, req_value, req_index, output ready);
endinterface

// ===== rtl/core/bkvt_rsp_if.sv =====
`timescale 1ns / 1ps
interface bkvt_rsp_if #(
    parameter int KEY_W   = bkvt_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_W = bkvt_pkg::DEF_VALUE_WIDTH
) ();
    import bkvt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [KEY_W-1:0]       out_key;
    logic [VALUE_W-1:0]     out_value;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;

    modport source (output valid, ok, out_key, out_value, entry_count, is_empty,
                    input ready);
    modport sink   (input valid, ok, out_key, out_value, entry_count, is_empty,
                    output ready);
endinterface

// ===== rtl/core/bounded_key_value_table.sv =====
`timescale 1ns / 1ps
// a key request scans the entries from position 0 until a hit or entry_count; an erase
// that moves the last entry into the hole adds a table read and a write; a read by index
// does one table read; an unknown func or an index out of range goes straight to the
// response; the scan reads one stored entry per cycle; one item in flight at a time; a
// finished result waits in the output register; reset: synchronous active low, clears
// count and result valid, capacity back to 256; contents not cleared, no clearing pass
module bounded_key_value_table #(
    parameter int DEPTH       = bkvt_pkg::DEF_DEPTH,
    parameter int KEY_WIDTH   = bkvt_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = bkvt_pkg::DEF_VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bkvt_req_if.sink                    i_req,
    bkvt_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_wr_en,
    input  logic [bkvt_pkg::CAP_W-1:0]  i_cfg_wr_data
);
    import bkvt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam int WW = KEY_WIDTH + VALUE_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_ACT    = 3'd2;
    localparam logic [2:0] ST_ERASE  = 3'd3;
    localparam logic [2:0] ST_IDX_RD = 3'd4;
    localparam logic [2:0] ST_IDX    = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [WW-1:0]          r_mem [DEPTH];
    logic [WW-1:0]          r_rd_data;

    logic [2:0]             r_state, n_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic                   r_rd_valid, n_rd_valid;
    logic [AW-1:0]          r_rd_idx, n_rd_idx;
    t_func                  r_func, n_func;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [INDEX_W-1:0]     r_idx, n_idx;
    logic                   r_found, n_found;
    logic [AW-1:0]          r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_hit_val, n_hit_val;
    logic                   r_res_ok, n_res_ok;
    logic [KEY_WIDTH-1:0]   r_res_key, n_res_key;
    logic [VALUE_WIDTH-1:0] r_res_value, n_res_value;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_ok;
    logic [KEY_WIDTH-1:0]   r_out_key;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic [CW-1:0]          r_out_count;
    logic                   load_out;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WW-1:0]          wr_data;

    logic                   accept;
    logic                   hit;
    logic                   room;
    logic                   idx_ok;
    logic [CW-1:0]          last;

    assign accept = i_req.valid && i_req.ready;
    assign hit    = r_rd_valid && (r_rd_data[WW-1:VALUE_WIDTH] == r_key);
    assign room   = (LW'(r_count) < LW'(r_cap)) && (LW'(r_count) < LW'(DEPTH));
    assign idx_ok = LW'(i_req.req_index) < LW'(r_count);
    assign last   = r_count - CW'(1);

    assign load_out = (r_state == ST_RESP) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_func      = r_func;
        n_key       = r_key;
        n_value     = r_value;
        n_idx       = r_idx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_hit_val   = r_hit_val;
        n_res_ok    = r_res_ok;
        n_res_key   = r_res_key;
        n_res_value = r_res_value;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {r_key, r_value};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func      = i_req.func;
                    n_key       = i_req.req_key;
                    n_value     = i_req.req_value;
                    n_idx       = i_req.req_index;
                    n_ptr       = '0;
                    n_found     = 1'b0;
                    n_res_ok    = 1'b0;
                    n_res_key   = '0;
                    n_res_value = '0;
                    case (i_req.func) inside
                        [FUNC_INSERT:FUNC_LOOKUP]: n_state = ST_SCAN;
                        FUNC_READ:                 n_state = idx_ok ? ST_IDX_RD : ST_RESP;
                        default:                   n_state = ST_RESP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_found   = 1'b1;
                    n_pos     = r_rd_idx;
                    n_hit_val = r_rd_data[VALUE_WIDTH-1:0];
                    n_state   = ST_ACT;
                end else if (r_ptr == r_count) begin
                    n_state   = ST_ACT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = r_ptr[AW-1:0];
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_ptr[AW-1:0];
                    n_ptr      = r_ptr + CW'(1);
                end
            end
            ST_ACT: begin
                n_state = ST_RESP;
                case (r_func)
                    FUNC_INSERT: begin
                        if (!r_found && room) begin
                            wr_en    = 1'b1;
                            wr_addr  = r_count[AW-1:0];
                            n_count  = r_count + CW'(1);
                            n_res_ok = 1'b1;
                        end
                    end
                    FUNC_UPDATE: begin
                        if (r_found) begin
                            wr_en    = 1'b1;
                            wr_addr  = r_pos;
                            n_res_ok = 1'b1;
                        end
                    end
                    FUNC_UPSERT: begin
                        if (r_found) begin
                            wr_en    = 1'b1;
                            wr_addr  = r_pos;
                            n_res_ok = 1'b1;
                        end else if (room) begin
                            wr_en    = 1'b1;
                            wr_addr  = r_count[AW-1:0];
                            n_count  = r_count + CW'(1);
                            n_res_ok = 1'b1;
                        end
                    end
                    FUNC_ERASE: begin
                        if (r_found) begin
                            if (CW'(r_pos) == last) begin
                                n_count  = last;
                                n_res_ok = 1'b1;
                            end else begin
                                // fetch the last entry to fill the hole
                                rd_en   = 1'b1;
                                rd_addr = last[AW-1:0];
                                n_state = ST_ERASE;
                            end
                        end
                    end
                    FUNC_LOOKUP: begin
                        if (r_found) begin
                            n_res_ok    = 1'b1;
                            n_res_value = r_hit_val;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ERASE: begin
                wr_en    = 1'b1;
                wr_addr  = r_pos;
                wr_data  = r_rd_data;
                n_count  = last;
                n_res_ok = 1'b1;
                n_state  = ST_RESP;
            end
            ST_IDX_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx);
                n_state = ST_IDX;
            end
            ST_IDX: begin
                n_res_ok    = 1'b1;
                n_res_key   = r_rd_data[WW-1:VALUE_WIDTH];
                n_res_value = r_rd_data[VALUE_WIDTH-1:0];
                n_state     = ST_RESP;
            end
            ST_RESP: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_rd_idx    <= n_rd_idx;
        r_func      <= n_func;
        r_key       <= n_key;
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_pos       <= n_pos;
        r_hit_val   <= n_hit_val;
        r_res_ok    <= n_res_ok;
        r_res_key   <= n_res_key;
        r_res_value <= n_res_value;
        if (load_out) begin
            r_out_ok    <= r_res_ok;
            r_out_key   <= r_res_key;
            r_out_value <= r_res_value;
            r_out_count <= r_count;
        end
    end

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.out_key     = r_out_key;
    assign o_rsp.out_value   = r_out_value;
    assign o_rsp.entry_count = COUNT_OUT_W'(r_out_count);
    assign o_rsp.is_empty    = (r_out_count == '0);

endmodule

// ===== rtl/core/bkvt_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_key_value_table_defines.svh"
module bkvt_checker #(
    parameter int DEPTH = bkvt_pkg::DEF_DEPTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic                              i_rsp_empty,
    input logic [bkvt_pkg::COUNT_OUT_W-1:0]  i_rsp_count
);
    import bkvt_pkg::*;

    localparam int LW = ($clog2(DEPTH + 1) > COUNT_OUT_W) ? $clog2(DEPTH + 1) : COUNT_OUT_W;

    `BKVT_ASSERT_ALWAYS(a_reset_clears_rsp, i_clk, !i_rst_n |=> !i_rsp_valid, "result valid after reset")
    `BKVT_ASSERT(a_rsp_held, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "result dropped while stalled")
    `BKVT_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready |=> !i_req_ready, "item taken while busy")
    `BKVT_ASSERT(a_empty_flag, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_empty == (i_rsp_count == '0)), "empty flag disagrees with count")
    `BKVT_ASSERT(a_count_bound, i_clk, i_rst_n, i_rsp_valid |-> (LW'(i_rsp_count) <= LW'(DEPTH)), "count above depth")

endmodule

bind bounded_key_value_table bkvt_checker #(
    .DEPTH (DEPTH)
) u_bkvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_empty (o_rsp.is_empty),
    .i_rsp_count (o_rsp.entry_count)
);
